@@ rtl/core/pdt_pkg.sv @@
package pdt_pkg;

	localparam int unsigned SEC_W = 32;
	localparam int unsigned US_W  = 20;
	localparam int unsigned IDX_W = 2;

	localparam logic [US_W-1:0] MICROS_PER_SEC  = 20'd1000000;
	localparam logic [US_W:0]   MICROS_PER_SEC1 = 21'd1000000;
	localparam logic [US_W:0]   MICROS_PER_SEC2 = 21'd2000000;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE         = 2'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD_SECONDS = 2'd1;
	localparam logic [IDX_W-1:0] REG_PERIOD_MICROS  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_NOT_DUE   = 2'd0;
	localparam logic [1:0] STATUS_FIRED     = 2'd1;
	localparam logic [1:0] STATUS_NO_PERIOD = 2'd2;
	localparam logic [1:0] STATUS_BACKWARD  = 2'd3;

	// fault codes
	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_BACKWARD = 2'd1;
	localparam logic [1:0] FAULT_OVERRUN  = 2'd2;

	typedef struct packed {
		logic [SEC_W-1:0] now_seconds;
		logic [US_W-1:0]  now_micros;
	} sample_t;

	typedef struct packed {
		logic [1:0] status;
		logic       toggle_out;
		logic       trigger_out;
		logic [1:0] fault_out;
	} result_t;

	typedef struct packed {
		logic             enable;
		logic [SEC_W-1:0] period_seconds;
		logic [US_W-1:0]  period_micros;
	} cfg_t;

	typedef struct packed {
		logic [SEC_W-1:0] start_seconds;
		logic [US_W-1:0]  start_micros;
		logic             toggle_flag;
		logic             trig_flag;
		logic [1:0]       fault_code;
	} state_t;

endpackage

@@ rtl/core/pdt_cfg_regs.sv @@
module pdt_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pdt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pdt_pkg::SEC_W-1:0]  cfg_data,
	output pdt_pkg::cfg_t              cfg
);

	pdt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdt_pkg::REG_ENABLE: begin
					cfg_q.enable <= cfg_data[0];
				end
				pdt_pkg::REG_PERIOD_SECONDS: begin
					cfg_q.period_seconds <= cfg_data;
				end
				pdt_pkg::REG_PERIOD_MICROS: begin
					cfg_q.period_micros <= cfg_data[pdt_pkg::US_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/pdt_step.sv @@
module pdt_step (
	input  pdt_pkg::cfg_t    cfg,
	input  pdt_pkg::state_t  st,
	input  pdt_pkg::sample_t item,
	output pdt_pkg::state_t  st_nxt,
	output pdt_pkg::result_t res
);

	logic                      borrow;
	logic                      behind;
	logic [pdt_pkg::SEC_W-1:0] ds;
	logic [pdt_pkg::US_W:0]    us_borrowed;
	logic [pdt_pkg::US_W:0]    dus_raw;
	logic [pdt_pkg::US_W:0]    dus_sub;
	logic [pdt_pkg::US_W-1:0]  dus;
	logic                      elapsed_zero;
	logic                      fire;
	logic                      overrun;
	logic [pdt_pkg::US_W:0]    us_sum;
	logic [pdt_pkg::US_W:0]    us_wrap;
	logic                      carry;
	logic [pdt_pkg::SEC_W-1:0] ss_adv;
	logic [1:0]                status;

	assign borrow = item.now_micros < st.start_micros;
	assign behind = (item.now_seconds < st.start_seconds) ||
		((item.now_seconds == st.start_seconds) && borrow);

	assign ds = item.now_seconds - st.start_seconds
		- {{(pdt_pkg::SEC_W-1){1'b0}}, borrow};
	assign us_borrowed = {1'b0, item.now_micros} + pdt_pkg::MICROS_PER_SEC1;

	// borrowed difference clamps at zero when the start micros are out of range
	always_comb begin
		if (!borrow) begin
			dus_raw = {1'b0, item.now_micros - st.start_micros};
		end else if (us_borrowed >= {1'b0, st.start_micros}) begin
			dus_raw = us_borrowed - {1'b0, st.start_micros};
		end else begin
			dus_raw = '0;
		end
	end

	assign elapsed_zero = (ds == '0) && (dus_raw == '0);
	// dus_raw stays below two million, so one subtract reduces it
	assign dus_sub = dus_raw - pdt_pkg::MICROS_PER_SEC1;
	assign dus = (dus_raw >= pdt_pkg::MICROS_PER_SEC1) ? dus_sub[pdt_pkg::US_W-1:0]
		: dus_raw[pdt_pkg::US_W-1:0];

	assign overrun = {1'b0, ds[pdt_pkg::SEC_W-1:1]} > cfg.period_seconds;
	assign fire = (ds > cfg.period_seconds) ||
		((ds == cfg.period_seconds) && (dus > cfg.period_micros));

	// start advance: micros sum can reach past two million for unnormalized values
	assign us_sum = {1'b0, st.start_micros} + {1'b0, cfg.period_micros};
	always_comb begin
		if (us_sum >= pdt_pkg::MICROS_PER_SEC2) begin
			us_wrap = us_sum - pdt_pkg::MICROS_PER_SEC2;
			carry   = 1'b1;
		end else if (us_sum >= pdt_pkg::MICROS_PER_SEC1) begin
			us_wrap = us_sum - pdt_pkg::MICROS_PER_SEC1;
			carry   = 1'b1;
		end else begin
			us_wrap = us_sum;
			carry   = 1'b0;
		end
	end
	assign ss_adv = st.start_seconds + cfg.period_seconds
		+ {{(pdt_pkg::SEC_W-1){1'b0}}, carry};

	always_comb begin
		st_nxt = st;
		status = pdt_pkg::STATUS_NOT_DUE;
		if ((cfg.period_seconds == '0) && (cfg.period_micros == '0)) begin
			status = pdt_pkg::STATUS_NO_PERIOD;
		end else if (cfg.enable) begin
			st_nxt.fault_code = pdt_pkg::FAULT_NONE;
			if (behind) begin
				st_nxt.start_seconds = item.now_seconds;
				st_nxt.start_micros  = item.now_micros;
				st_nxt.fault_code    = pdt_pkg::FAULT_BACKWARD;
				status               = pdt_pkg::STATUS_BACKWARD;
			end else if (elapsed_zero) begin
				status = pdt_pkg::STATUS_NOT_DUE;
			end else if (fire) begin
				st_nxt.toggle_flag = ~st.toggle_flag;
				st_nxt.trig_flag   = 1'b1;
				status             = pdt_pkg::STATUS_FIRED;
				if (overrun) begin
					st_nxt.start_seconds = item.now_seconds;
					st_nxt.start_micros  = item.now_micros;
					st_nxt.fault_code    = pdt_pkg::FAULT_OVERRUN;
				end else begin
					st_nxt.start_seconds = ss_adv;
					st_nxt.start_micros  = us_wrap[pdt_pkg::US_W-1:0];
				end
			end else begin
				st_nxt.trig_flag = 1'b0;
			end
		end
	end

	assign res.status      = status;
	assign res.toggle_out  = st_nxt.toggle_flag;
	assign res.trigger_out = st_nxt.trig_flag;
	assign res.fault_out   = st_nxt.fault_code;

endmodule

@@ rtl/core/periodic_task_deadline_timer.sv @@
// An accepted item is held in the sample register, then in the result register.
// Throughput: one item per cycle unless result_ready stalls the result register; the
// timer state updates in the same cycle that item enters the result register.
// The result register stalls on result_ready; the sample register refills behind it.
// Reset (arst_n low, asynchronous): config registers, timer state and valid flags
// clear to zero; the sample and result data registers are not reset.
module periodic_task_deadline_timer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  pdt_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output pdt_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [pdt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pdt_pkg::SEC_W-1:0]  cfg_data
);

	pdt_pkg::cfg_t    cfg;
	pdt_pkg::state_t  state_q;
	pdt_pkg::state_t  state_nxt;
	pdt_pkg::sample_t item_s1;
	pdt_pkg::result_t res_nxt;
	pdt_pkg::result_t result_q;
	logic             valid_s1;
	logic             result_valid_q;
	logic             advance;

	pdt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdt_step u_step (
		.cfg    (cfg),
		.st     (state_q),
		.item   (item_s1),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// stage 1 moves into the result register when that register is free or being drained
	assign advance      = !result_valid_q || result_ready;
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_fired_sets_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == pdt_pkg::STATUS_FIRED) |-> result.trigger_out)
		else $error("fired result without trigger");

	a_backward_fault: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == pdt_pkg::STATUS_BACKWARD)
		|-> (result.fault_out == pdt_pkg::FAULT_BACKWARD))
		else $error("backward status without backward fault");

	a_stage_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> result_valid)
		else $error("item lost between stage 1 and result register");

	a_fault_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fault_out != 2'd3))
		else $error("undefined fault code");
`endif

endmodule
